### src/pcfl_pkg.sv
// Shared types and constants for the per-core page free list allocator.
// Holds the request and response payloads, the control interface between
// the controller and the datapath, and the default parameter values.
package pcfl_pkg;

  localparam int CoresDef     = 8;
  localparam int PagesDef     = 32768;
  localparam int PageBytesDef = 4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_LOWEST = 1'b0;
  localparam logic CFG_TOP    = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_MEM   = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [2:0]  core;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [31:0] page_address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic take;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic needs_pop;
  } stat_t;

endpackage

### src/pcfl_ctrl.sv
// Controller of the page free list allocator: request and result handshakes.
// Drives the datapath through pcfl_pkg::cmd_t and reads pcfl_pkg::stat_t.
module pcfl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  pcfl_pkg::stat_t stat_i,
  output pcfl_pkg::cmd_t  cmd_o
);
  import pcfl_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   take;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign cmd_o.take  = take;
  assign cmd_o.pop   = (state_q == ST_POP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (take && stat_i.needs_pop) begin
            state_q     <= ST_POP;
            out_valid_q <= 1'b0;
          end else if (take) begin
            out_valid_q <= 1'b1;
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_POP: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b1;
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

### src/pcfl_datapath.sv
// Datapath of the page free list allocator: configuration registers, list
// heads, the link memory and the result register. Uses pcfl_pkg.
module pcfl_datapath #(
  parameter int CORES      = pcfl_pkg::CoresDef,
  parameter int PAGES      = pcfl_pkg::PagesDef,
  parameter int PAGE_BYTES = pcfl_pkg::PageBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic            cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  input  pcfl_pkg::req_t  in_data_i,
  input  pcfl_pkg::cmd_t  cmd_i,
  output pcfl_pkg::stat_t stat_o,
  output pcfl_pkg::rsp_t  out_data_o
);
  import pcfl_pkg::*;

  localparam int SH     = $clog2(PAGE_BYTES);
  localparam int IDX_W  = $clog2(PAGES);
  localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int PG_W   = 33 - SH;

  logic [31:0]      lowest_q;
  logic [31:0]      top_q;
  logic [IDX_W-1:0] heads_q [CORES];
  logic [CORES-1:0] hvalid_q;
  logic [IDX_W:0]   links [PAGES];
  logic [IDX_W:0]   link_q;
  logic [CORE_W-1:0] pick_q;
  logic [IDX_W-1:0] idx_q;
  rsp_t             rsp_q;
  rsp_t             rsp_d;

  logic [PG_W-1:0]   base_pg;
  logic [32:0]       base;
  logic              core_ok;
  logic [CORE_W-1:0] own;
  logic              own_hit;
  logic              any_valid;
  logic [CORE_W-1:0] first;
  logic [CORE_W-1:0] pick;
  logic [PG_W-1:0]   diff;
  logic              free_ok;
  logic [IDX_W-1:0]  free_idx;
  logic              do_free;
  logic              do_read;
  logic              load;
  logic [32:0]       alloc_addr;

  always_comb begin
    base_pg = PG_W'((33'(lowest_q) + 33'(PAGE_BYTES - 1)) >> SH);
    base    = 33'(base_pg) << SH;
    core_ok = 32'(in_data_i.core) < 32'(CORES);
    own     = CORE_W'(in_data_i.core);
    own_hit = core_ok && hvalid_q[own];
    any_valid = |hvalid_q;
    first = '0;
    for (int c = CORES - 1; c >= 0; c--) begin
      if (hvalid_q[c]) begin
        first = CORE_W'(c);
      end
    end
    pick = own_hit ? own : first;
    diff = PG_W'(in_data_i.address[31:SH]) - base_pg;
    free_ok = (in_data_i.address[SH-1:0] == '0) && (in_data_i.address >= lowest_q) &&
              (in_data_i.address < top_q) && core_ok && (33'(diff) < 33'(PAGES));
    free_idx = diff[IDX_W-1:0];
    alloc_addr = base + (33'(idx_q) << SH);
  end

  assign stat_o.needs_pop = (in_data_i.operation == OP_ALLOC) && any_valid;
  assign do_free = cmd_i.take && (in_data_i.operation == OP_FREE) && free_ok;
  assign do_read = cmd_i.take && stat_o.needs_pop;
  assign load    = (cmd_i.take && !stat_o.needs_pop) || cmd_i.pop;

  always_comb begin
    rsp_d.page_address = '0;
    rsp_d.status       = STATUS_OK;
    if (cmd_i.pop) begin
      rsp_d.page_address = alloc_addr[31:0];
    end else if (in_data_i.operation == OP_FREE) begin
      rsp_d.status = free_ok ? STATUS_OK : STATUS_BAD_FREE;
    end else begin
      rsp_d.status = STATUS_NO_MEM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q <= '0;
      top_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOWEST: lowest_q <= cfg_data_i;
        CFG_TOP:    top_q    <= cfg_data_i;
        default:    lowest_q <= lowest_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
    end else if (do_free) begin
      hvalid_q[own] <= 1'b1;
    end else if (cmd_i.pop) begin
      hvalid_q[pick_q] <= link_q[IDX_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_free) begin
      heads_q[own] <= free_idx;
    end else if (cmd_i.pop) begin
      heads_q[pick_q] <= link_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_free) begin
      links[free_idx] <= {hvalid_q[own], hvalid_q[own] ? heads_q[own] : '0};
    end
    if (do_read) begin
      link_q <= links[heads_q[pick]];
      pick_q <= pick;
      idx_q  <= heads_q[pick];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_data_o = rsp_q;

endmodule

### src/per_core_page_free_list_allocator.sv
// Per-core page frame allocator with one LIFO free list for each core.
// Top level; instantiates pcfl_ctrl and pcfl_datapath, types from pcfl_pkg.
//
// Requests enter on the in channel as pcfl_pkg::req_t. A free checks the
// byte address against alignment, lowest_address and top_address and pushes
// the page onto the requesting core's list. An allocate pops from the
// requester's list, or else from the lowest-numbered core with a free page.
// Every request yields exactly one result transfer on the out channel.
// A free, and an allocate that finds every list empty, give a result that is
// valid the cycle after the request transfer. An allocate that pops first
// passes the registered read of the link memory, then the result register.
// One request is in flight at a time; in_ready_o is low while a pop is
// pending. The result register lets a new request enter in the same cycle
// that the waiting result is taken; while the receiver stalls, in_ready_o
// stays low and the result holds. Configuration writes on the cfg channel
// are always taken and are meant for idle periods. Reset empties all lists
// and clears both address registers; the link memory needs no clearing.
module per_core_page_free_list_allocator #(
  parameter int CORES      = pcfl_pkg::CoresDef,
  parameter int PAGES      = pcfl_pkg::PagesDef,
  parameter int PAGE_BYTES = pcfl_pkg::PageBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pcfl_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pcfl_pkg::rsp_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [31:0]    cfg_data_i
);
  import pcfl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  pcfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pcfl_datapath #(
    .CORES      (CORES),
    .PAGES      (PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

### src/pcfl_checker.sv
// Port-level checks for the per-core page free list allocator.
// Depends on pcfl_pkg; bound to per_core_page_free_list_allocator below.
module pcfl_port_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input pcfl_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input pcfl_pkg::rsp_t out_data_o
);
  import pcfl_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result changed.");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("Request taken while a result is stalled.");

  a_free_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.operation == OP_FREE) |=> out_valid_o)
    else $error("Free result not valid one cycle after the transfer.");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_OK) |-> (out_data_o.page_address == '0))
    else $error("Failed request returned a nonzero address.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STATUS_OK) ||
      (out_data_o.status == STATUS_NO_MEM) || (out_data_o.status == STATUS_BAD_FREE))
    else $error("Result status code out of range.");

endmodule

bind per_core_page_free_list_allocator pcfl_port_checker u_pcfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### bench/pcfl_checker.sv
// Checker for the per-core page free list allocator: watches the request,
// response and register channels, keeps its own copy of the free lists and
// compares every response transfer. Depends on pcfl_pkg for payload types.
module pcfl_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  pcfl_pkg::req_t in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  pcfl_pkg::rsp_t out_data_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic           cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  output int             mismatches_o,
  output int             pending_o
);
  import pcfl_pkg::*;

  localparam int IdxW = $clog2(PagesDef);

  logic [31:0]   lowest_addr;
  logic [31:0]   top_addr;
  logic [IdxW-1:0] head_idx [CoresDef];
  logic          head_ok [CoresDef];
  logic [IdxW:0] link_mem [PagesDef];
  rsp_t          page_rsp_q [$];
  int            fails = 0;

  function automatic rsp_t serve_page_request(input req_t r);
    logic [63:0]     base;
    logic [63:0]     idx;
    logic [IdxW-1:0] pg;
    logic [IdxW:0]   link;
    rsp_t            rsp;
    int              pick;
    int              c;
    rsp = '0;
    base = ((64'(lowest_addr) + 64'(PageBytesDef) - 64'd1) / 64'(PageBytesDef)) *
           64'(PageBytesDef);
    if (r.operation == OP_FREE) begin
      if ((r.address % 32'(PageBytesDef)) != 32'd0 || r.address < lowest_addr ||
          r.address >= top_addr || int'(r.core) >= CoresDef) begin
        rsp.status = STATUS_BAD_FREE;
      end else begin
        idx = (64'(r.address) - base) / 64'(PageBytesDef);
        if (idx >= 64'(PagesDef)) begin
          rsp.status = STATUS_BAD_FREE;
        end else begin
          link_mem[idx[IdxW-1:0]] = head_ok[r.core] ? {1'b1, head_idx[r.core]} : '0;
          head_idx[r.core] = idx[IdxW-1:0];
          head_ok[r.core] = 1'b1;
        end
      end
    end else begin
      pick = -1;
      if (int'(r.core) < CoresDef && head_ok[r.core]) begin
        pick = int'(r.core);
      end else begin
        for (c = 0; c < CoresDef; c++) begin
          if (pick < 0 && head_ok[c]) pick = c;
        end
      end
      if (pick < 0) begin
        rsp.status = STATUS_NO_MEM;
      end else begin
        pg = head_idx[pick];
        link = link_mem[pg];
        if (link[IdxW]) begin
          head_idx[pick] = link[IdxW-1:0];
          head_ok[pick] = 1'b1;
        end else begin
          head_idx[pick] = '0;
          head_ok[pick] = 1'b0;
        end
        rsp.page_address = 32'(base + 64'(pg) * 64'(PageBytesDef));
        rsp.status = STATUS_OK;
      end
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      lowest_addr = '0;
      top_addr = '0;
      for (int c = 0; c < CoresDef; c++) begin
        head_idx[c] = '0;
        head_ok[c] = 1'b0;
      end
      page_rsp_q.delete();
      fails = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_LOWEST) lowest_addr = cfg_data_i;
        else top_addr = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) page_rsp_q.push_back(serve_page_request(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (page_rsp_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("Unexpected response transfer: page_address %h status %0d",
                     out_data_i.page_address, out_data_i.status);
          end
        end else begin
          want = page_rsp_q.pop_front();
          if (out_data_i.page_address !== want.page_address ||
              out_data_i.status !== want.status) begin
            fails++;
            if (fails <= 10) begin
              $display("Response mismatch: page_address exp %h got %h, status exp %0d got %0d",
                       want.page_address, out_data_i.page_address, want.status,
                       out_data_i.status);
            end
          end
        end
      end
      mismatches_o <= fails;
      pending_o <= page_rsp_q.size();
    end
  end

endmodule

### bench/per_core_page_free_list_allocator_tb.sv
// Testbench top for per_core_page_free_list_allocator: drives directed and
// random allocate and free requests and register writes under varying idle
// patterns. Depends on pcfl_pkg, the block and pcfl_checker.
module per_core_page_free_list_allocator_tb;
  import pcfl_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam logic [31:0] DirBase = 32'h0010_1000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_LOWEST;
  logic [31:0] cfg_data = '0;
  int          mismatches;
  int          pending;
  int          quiet_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic [31:0] lowest_now = '0;
  logic [31:0] top_now = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  per_core_page_free_list_allocator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  pcfl_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("per_core_page_free_list_allocator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] dir_page(input int unsigned k);
    return DirBase + 32'(k) * 32'(PageBytesDef);
  endfunction

  function automatic logic [31:0] pick_free_addr();
    logic [63:0] base;
    logic [31:0] a;
    base = ((64'(lowest_now) + 64'(PageBytesDef) - 64'd1) / 64'(PageBytesDef)) *
           64'(PageBytesDef);
    case ($urandom_range(9))
      0: a = $urandom();
      1: a = $urandom() & ~32'(PageBytesDef - 1);
      2: a = 32'(base + 64'(PagesDef - 2 + $urandom_range(3)) * 64'(PageBytesDef));
      3: a = (top_now & ~32'(PageBytesDef - 1)) - 32'($urandom_range(1) * PageBytesDef);
      4: a = 32'(base + 64'($urandom_range(PageBytesDef - 1, 1)));
      default: a = 32'(base + 64'($urandom_range(47)) * 64'(PageBytesDef));
    endcase
    return a;
  endfunction

  task automatic send_req(input logic op, input logic [2:0] core, input logic [31:0] addr);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, core: core, address: addr};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Registers are only written once every response has come back.
  task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LOWEST;
    cfg_data <= lo;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_index <= CFG_TOP;
    cfg_data <= hi;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    lowest_now = lo;
    top_now = hi;
  endtask

  task automatic run_phase(input logic [31:0] lo, input logic [31:0] hi,
                           input int unsigned src, input int unsigned sink,
                           input int unsigned free_pct, input int count);
    logic op;
    set_window(lo, hi);
    src_idle_pct = src;
    sink_stall_pct = sink;
    repeat (count) begin
      op = ($urandom_range(99) < free_pct) ? OP_FREE : OP_ALLOC;
      send_req(op, 3'($urandom_range(CoresDef - 1)),
               (op == OP_FREE) ? pick_free_addr() : $urandom());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_window(32'h0010_0801, 32'h0820_0000);
    send_req(OP_ALLOC, 3'd0, 32'h0000_0000);
    send_req(OP_ALLOC, 3'd7, 32'hFFFF_FFFF);
    send_req(OP_FREE, 3'd1, dir_page(0) + 32'd1);
    send_req(OP_FREE, 3'd1, 32'h0010_0000);
    send_req(OP_FREE, 3'd2, 32'h0820_0000);
    send_req(OP_FREE, 3'd3, dir_page(PagesDef));
    send_req(OP_FREE, 3'd7, dir_page(PagesDef - 1));
    send_req(OP_FREE, 3'd0, dir_page(0));
    send_req(OP_FREE, 3'd0, dir_page(1));
    send_req(OP_FREE, 3'd0, dir_page(1));
    send_req(OP_ALLOC, 3'd0, 32'h0000_0000);
    send_req(OP_ALLOC, 3'd0, 32'h0000_0000);
    send_req(OP_ALLOC, 3'd0, 32'h0000_0000);
    send_req(OP_ALLOC, 3'd0, 32'h0000_0000);
    send_req(OP_ALLOC, 3'd3, 32'h0000_0000);
    send_req(OP_FREE, 3'd2, 32'hFFFF_F000);
    send_req(OP_FREE, 3'd1, 32'h0000_0000);
    send_req(OP_FREE, 3'd5, 32'h081F_F000);
    send_req(OP_FREE, 3'd5, dir_page(5));
    send_req(OP_ALLOC, 3'd5, 32'hFFFF_FFFF);
    send_req(OP_FREE, 3'd6, dir_page(9));
    send_req(OP_FREE, 3'd2, dir_page(8));
    send_req(OP_ALLOC, 3'd4, 32'h0000_0000);
    send_req(OP_ALLOC, 3'd4, 32'h0000_0000);
    send_req(OP_ALLOC, 3'd4, 32'h0000_0000);

    run_phase(32'h0010_0801, 32'h0820_0000, 0, 0, 55, 200);
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 88, 0, 60, 180);
    run_phase(32'hFFFF_0000, 32'hFFFF_FFFF, 0, 88, 50, 180);
    run_phase(32'h1234_5678, 32'h4000_0000, 23, 23, 45, 200);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 30, 80);
    run_phase(32'h0000_0000, 32'h0000_0000, 88, 88, 50, 80);
    run_phase(32'h0000_2000, 32'h0008_0000, 23, 23, 50, 230);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("per_core_page_free_list_allocator test passed");
    end else begin
      $display("per_core_page_free_list_allocator test failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/pcfl_pkg.sv
src/pcfl_ctrl.sv
src/pcfl_datapath.sv
src/per_core_page_free_list_allocator.sv
src/pcfl_checker.sv
bench/pcfl_checker.sv
bench/per_core_page_free_list_allocator_tb.sv
